// ===== rtl/rqps_pkg.sv =====
package rqps_pkg;

  // Default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int LINE_BITS_DEF   = 10;
  localparam int ID_BITS_DEF     = 8;
  localparam int SCORE_BITS      = 10;

  // Command codes
  localparam logic [1:0] CMD_ADMIT_TAIL  = 2'd0;
  localparam logic [1:0] CMD_ADMIT_FRONT = 2'd1;
  localparam logic [1:0] CMD_REPORT      = 2'd2;

  // Fetch outcome codes
  localparam logic [1:0] OC_EXECUTED = 2'd0;
  localparam logic [1:0] OC_FAULT    = 2'd1;

  // Policy codes
  localparam logic [1:0] POL_FCFS  = 2'd0;
  localparam logic [1:0] POL_AGING = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ZERO_LEN = 2'd2;
  localparam logic [1:0] ST_IDLE     = 2'd3;

  // Configuration register indexes and reset values
  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;
  localparam logic [1:0] POLICY_RESET  = 2'd0;
  localparam logic [5:0] QUANTUM_RESET = 6'd2;

  // Handshake between front end and engine
  typedef struct packed {
    logic start;
    logic take;
  } eng_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_sts_t;

endpackage

// ===== rtl/rqps_ram.sv =====
module rqps_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rqps_engine.sv =====
module rqps_engine #(
  parameter int QUEUE_DEPTH = rqps_pkg::QUEUE_DEPTH_DEF,
  parameter int LINE_BITS   = rqps_pkg::LINE_BITS_DEF,
  parameter int ID_BITS     = rqps_pkg::ID_BITS_DEF,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rqps_pkg::eng_ctl_t             ctl,
  output rqps_pkg::eng_sts_t             sts,
  input  logic [1:0]                     policy_mode,
  input  logic [5:0]                     quantum_lines,
  input  logic [1:0]                     cmd,
  input  logic [ID_BITS-1:0]             proc_id,
  input  logic [LINE_BITS-1:0]           line_count,
  input  logic [rqps_pkg::SCORE_BITS-1:0] start_score,
  input  logic [1:0]                     fetch_outcome,
  output logic                           fetch_valid,
  output logic [ID_BITS-1:0]             fetch_proc,
  output logic [LINE_BITS-1:0]           fetch_line,
  output logic                           retired_valid,
  output logic [ID_BITS-1:0]             retired_proc,
  output logic [1:0]                     status,
  output logic [CW-1:0]                  waiting_count
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int SC = rqps_pkg::SCORE_BITS;
  localparam int EW = ID_BITS + 2 * LINE_BITS + SC;
  localparam int SW = CW + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_AGE_RD   = 4'd2;
  localparam logic [3:0] S_AGE_WR   = 4'd3;
  localparam logic [3:0] S_AGE_END  = 4'd4;
  localparam logic [3:0] S_SHIFT_RD = 4'd5;
  localparam logic [3:0] S_SHIFT_WR = 4'd6;
  localparam logic [3:0] S_INS      = 4'd7;
  localparam logic [3:0] S_POP_RD   = 4'd8;
  localparam logic [3:0] S_POP_WR   = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]           state;
  // latched transaction
  logic [1:0]           in_cmd;
  logic [ID_BITS-1:0]   in_id;
  logic [LINE_BITS-1:0] in_len;
  logic [SC-1:0]        in_score;
  logic [1:0]           in_oc;
  // current process
  logic                 cur_valid;
  logic [ID_BITS-1:0]   cur_id;
  logic [LINE_BITS-1:0] cur_pc;
  logic [LINE_BITS-1:0] cur_len;
  logic [SC-1:0]        cur_score;
  logic [5:0]           turn;
  // circular queue
  logic [IW-1:0]        head;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        pos;
  logic                 found;
  // result
  logic                 ret_v;
  logic [ID_BITS-1:0]   ret_id;
  logic [1:0]           st;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [IW-1:0]        mem_raddr;
  logic [EW-1:0]        mem_wdata;
  logic [EW-1:0]        mem_rdata;

  logic                 full;
  logic                 admit;
  logic                 admit_ok;
  logic                 rep;
  logic                 executed;
  logic [LINE_BITS-1:0] pc_adv;
  logic                 line_done;
  logic [5:0]           turn_inc;
  logic                 rr_mode;
  logic                 rr_req;
  logic [IW-1:0]        front;
  logic [SC-1:0]        rd_score;
  logic [SC-1:0]        aged;

  // Logical queue position to memory address
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(k);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  rqps_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Decisions for the latched transaction
  always_comb begin
    full      = (count == CW'(QUEUE_DEPTH));
    admit     = (in_cmd == rqps_pkg::CMD_ADMIT_TAIL) || (in_cmd == rqps_pkg::CMD_ADMIT_FRONT);
    admit_ok  = admit && (in_len != '0) && !full;
    rep       = (in_cmd == rqps_pkg::CMD_REPORT) && cur_valid && !in_oc[1];
    executed  = (in_oc == rqps_pkg::OC_EXECUTED);
    pc_adv    = executed ? cur_pc + LINE_BITS'(1) : cur_pc;
    line_done = (pc_adv >= cur_len);
    turn_inc  = executed ? turn + 6'd1 : turn;
    rr_mode   = (policy_mode != rqps_pkg::POL_FCFS) && (policy_mode != rqps_pkg::POL_AGING);
    rr_req    = rep && rr_mode && !line_done && (!executed || (turn_inc >= quantum_lines));
    front     = (head == '0) ? IW'(QUEUE_DEPTH - 1) : head - IW'(1);
    rd_score  = mem_rdata[SC-1:0];
    aged      = (rd_score != '0) ? rd_score - SC'(1) : '0;
  end

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = phys(head, count);
    mem_wdata = {cur_id, pc_adv, cur_len, cur_score};
    mem_raddr = head;
    case (state)
      S_DECIDE: begin
        if (admit_ok) begin
          mem_we    = 1'b1;
          mem_waddr = (in_cmd == rqps_pkg::CMD_ADMIT_FRONT) ? front : phys(head, count);
          mem_wdata = {in_id, LINE_BITS'(0), in_len, in_score};
        end else if (rr_req && !full) begin
          mem_we = 1'b1;
        end
      end
      S_AGE_RD: mem_raddr = phys(head, idx);
      S_AGE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head, idx);
        mem_wdata = {mem_rdata[EW-1:SC], aged};
      end
      S_SHIFT_RD: mem_raddr = phys(head, idx - CW'(1));
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head, idx);
        mem_wdata = mem_rdata;
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head, pos);
        mem_wdata = {cur_id, cur_pc, cur_len, cur_score};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_valid <= 1'b0;
      turn      <= '0;
      head      <= '0;
      count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            in_cmd   <= cmd;
            in_id    <= proc_id;
            in_len   <= line_count;
            in_score <= start_score;
            in_oc    <= fetch_outcome;
            ret_v    <= 1'b0;
            ret_id   <= '0;
            st       <= rqps_pkg::ST_OK;
            state    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_POP_RD;
          if (admit) begin
            if (in_len == '0) begin
              st <= rqps_pkg::ST_ZERO_LEN;
            end else if (full) begin
              st <= rqps_pkg::ST_FULL;
            end else begin
              count <= count + CW'(1);
              if (in_cmd == rqps_pkg::CMD_ADMIT_FRONT) begin
                head <= front;
              end
            end
          end else if (in_cmd == rqps_pkg::CMD_REPORT) begin
            if (!cur_valid) begin
              st <= rqps_pkg::ST_IDLE;
            end else if (in_oc[1]) begin
              ret_v     <= 1'b1;
              ret_id    <= cur_id;
              cur_valid <= 1'b0;
            end else if (policy_mode == rqps_pkg::POL_FCFS) begin
              cur_pc <= pc_adv;
              if (line_done) begin
                ret_v     <= 1'b1;
                ret_id    <= cur_id;
                cur_valid <= 1'b0;
              end
            end else if (policy_mode == rqps_pkg::POL_AGING) begin
              cur_pc <= pc_adv;
              idx    <= '0;
              found  <= 1'b0;
              pos    <= count;
              state  <= S_AGE_RD;
            end else begin
              cur_pc <= pc_adv;
              if (line_done) begin
                ret_v     <= 1'b1;
                ret_id    <= cur_id;
                cur_valid <= 1'b0;
              end else if (!rr_req) begin
                turn <= turn_inc;
              end else if (!full) begin
                count     <= count + CW'(1);
                cur_valid <= 1'b0;
              end else begin
                turn <= '0;
              end
            end
          end
        end
        // age every waiting entry, find first score not below the current one
        S_AGE_RD: begin
          state <= (idx == count) ? S_AGE_END : S_AGE_WR;
        end
        S_AGE_WR: begin
          if (!found && (aged >= cur_score)) begin
            found <= 1'b1;
            pos   <= idx;
          end
          idx   <= idx + CW'(1);
          state <= S_AGE_RD;
        end
        S_AGE_END: begin
          if (cur_pc >= cur_len) begin
            ret_v     <= 1'b1;
            ret_id    <= cur_id;
            cur_valid <= 1'b0;
            state     <= S_POP_RD;
          end else if (!full) begin
            idx   <= count;
            state <= S_SHIFT_RD;
          end else begin
            state <= S_POP_RD;
          end
        end
        // move entries at and behind the insert point back by one
        S_SHIFT_RD: begin
          state <= (idx == pos) ? S_INS : S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx   <= idx - CW'(1);
          state <= S_SHIFT_RD;
        end
        S_INS: begin
          count     <= count + CW'(1);
          cur_valid <= 1'b0;
          state     <= S_POP_RD;
        end
        // promote the head entry when nothing is current
        S_POP_RD: begin
          state <= (!cur_valid && (count != '0)) ? S_POP_WR : S_DONE;
        end
        S_POP_WR: begin
          cur_id    <= mem_rdata[SC+2*LINE_BITS +: ID_BITS];
          cur_pc    <= mem_rdata[SC+LINE_BITS +: LINE_BITS];
          cur_len   <= mem_rdata[SC +: LINE_BITS];
          cur_score <= mem_rdata[SC-1:0];
          cur_valid <= 1'b1;
          turn      <= '0;
          head      <= phys(head, CW'(1));
          count     <= count - CW'(1);
          state     <= S_DONE;
        end
        S_DONE: begin
          if (ctl.take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sts.idle      = (state == S_IDLE);
  assign sts.done      = (state == S_DONE);
  assign fetch_valid   = cur_valid;
  assign fetch_proc    = cur_valid ? cur_id : '0;
  assign fetch_line    = cur_valid ? cur_pc : '0;
  assign retired_valid = ret_v;
  assign retired_proc  = ret_id;
  assign status        = st;
  assign waiting_count = count;

endmodule

// ===== rtl/ready_queue_process_scheduler.sv =====
// Channel  Handshake            Payload
// in       in_valid / in_stall  cmd, proc_id, line_count, start_score, fetch_outcome
// out      out_valid / out_stall fetch_valid, fetch_proc, fetch_line, retired_valid,
//                               retired_proc, status, waiting_count
// cfg      cfg_we               cfg_index, cfg_data
//
// One transaction at a time through a single-port-write, registered-read queue memory.
// Aging reports read and rewrite each of the N waiting entries, then, unless the process
// retires or the queue is full, move back the M entries behind the insert point.
// Synchronous reset clears control state; the queue memory needs no clearing.
// The result register lets a new transaction in while out_stall holds the last result.
module ready_queue_process_scheduler #(
  parameter int QUEUE_DEPTH = rqps_pkg::QUEUE_DEPTH_DEF,
  parameter int LINE_BITS   = rqps_pkg::LINE_BITS_DEF,
  parameter int ID_BITS     = rqps_pkg::ID_BITS_DEF,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [5:0]                      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      cmd,
  input  logic [ID_BITS-1:0]              proc_id,
  input  logic [LINE_BITS-1:0]            line_count,
  input  logic [rqps_pkg::SCORE_BITS-1:0] start_score,
  input  logic [1:0]                      fetch_outcome,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            fetch_valid,
  output logic [ID_BITS-1:0]              fetch_proc,
  output logic [LINE_BITS-1:0]            fetch_line,
  output logic                            retired_valid,
  output logic [ID_BITS-1:0]              retired_proc,
  output logic [1:0]                      status,
  output logic [CW-1:0]                   waiting_count
);

  logic [1:0]           policy_mode;
  logic [5:0]           quantum_lines;
  rqps_pkg::eng_ctl_t   ctl;
  rqps_pkg::eng_sts_t   sts;
  logic                 out_free;
  logic                 e_fetch_valid;
  logic [ID_BITS-1:0]   e_fetch_proc;
  logic [LINE_BITS-1:0] e_fetch_line;
  logic                 e_retired_valid;
  logic [ID_BITS-1:0]   e_retired_proc;
  logic [1:0]           e_status;
  logic [CW-1:0]        e_waiting_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode   <= rqps_pkg::POLICY_RESET;
      quantum_lines <= rqps_pkg::QUANTUM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rqps_pkg::REG_POLICY:  policy_mode   <= cfg_data[1:0];
        rqps_pkg::REG_QUANTUM: quantum_lines <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = !sts.idle;
  assign out_free  = !out_valid || !out_stall;
  assign ctl.start = in_valid && sts.idle;
  assign ctl.take  = sts.done && out_free;

  rqps_engine #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .LINE_BITS  (LINE_BITS),
    .ID_BITS    (ID_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .policy_mode  (policy_mode),
    .quantum_lines(quantum_lines),
    .cmd          (cmd),
    .proc_id      (proc_id),
    .line_count   (line_count),
    .start_score  (start_score),
    .fetch_outcome(fetch_outcome),
    .fetch_valid  (e_fetch_valid),
    .fetch_proc   (e_fetch_proc),
    .fetch_line   (e_fetch_line),
    .retired_valid(e_retired_valid),
    .retired_proc (e_retired_proc),
    .status       (e_status),
    .waiting_count(e_waiting_count)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      fetch_valid   <= e_fetch_valid;
      fetch_proc    <= e_fetch_proc;
      fetch_line    <= e_fetch_line;
      retired_valid <= e_retired_valid;
      retired_proc  <= e_retired_proc;
      status        <= e_status;
      waiting_count <= e_waiting_count;
    end
  end

endmodule

// ===== test/ready_queue_process_scheduler_test.sv =====
`timescale 1ns / 100ps

module ready_queue_process_scheduler_test;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] proc_id;
    logic [9:0] line_count;
    logic [9:0] start_score;
    logic [1:0] fetch_outcome;
  } request_t;

  typedef struct packed {
    logic       fetch_valid;
    logic [7:0] fetch_proc;
    logic [9:0] fetch_line;
    logic       retired_valid;
    logic [7:0] retired_proc;
    logic [1:0] status;
    logic [4:0] waiting_count;
  } outcome_t;

  typedef struct packed {
    logic [7:0] id;
    logic [9:0] pc;
    logic [9:0] len;
    logic [9:0] score;
  } proc_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [5:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic [7:0] proc_id = '0;
  logic [9:0] line_count = '0;
  logic [9:0] start_score = '0;
  logic [1:0] fetch_outcome = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic fetch_valid;
  logic [7:0] fetch_proc;
  logic [9:0] fetch_line;
  logic retired_valid;
  logic [7:0] retired_proc;
  logic [1:0] status;
  logic [4:0] waiting_count;

  ready_queue_process_scheduler uut (.*);

  // scheduler shadow state
  proc_t      ready_q[$];
  proc_t      running;
  logic       running_valid;
  logic [5:0] turns;
  logic [1:0] policy;
  logic [5:0] quantum;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int hold_off = 0;
  int gap = 0;
  logic was_accepted = 1'b0;

  initial forever #6 clk = ~clk;

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // insert ahead of first entry with score >= own
  function automatic int score_slot(proc_t p);
    int pos = 0;
    while (pos < ready_q.size() && ready_q[pos].score < p.score) pos++;
    return pos;
  endfunction

  function automatic outcome_t schedule(request_t r);
    outcome_t o;
    logic [1:0] st = rqps_pkg::ST_OK;
    logic ret = 1'b0;
    logic [7:0] ret_id = '0;
    proc_t p;
    logic requeue;
    o = '0;
    if (r.cmd == rqps_pkg::CMD_ADMIT_TAIL || r.cmd == rqps_pkg::CMD_ADMIT_FRONT) begin
      p = '{id: r.proc_id, pc: 10'd0, len: r.line_count, score: r.start_score};
      if (r.line_count == 0) st = rqps_pkg::ST_ZERO_LEN;
      else if (ready_q.size() >= DEPTH) st = rqps_pkg::ST_FULL;
      else if (r.cmd == rqps_pkg::CMD_ADMIT_TAIL) ready_q.push_back(p);
      else ready_q.push_front(p);
    end else if (r.cmd == rqps_pkg::CMD_REPORT) begin
      if (!running_valid) st = rqps_pkg::ST_IDLE;
      else if (r.fetch_outcome >= 2) ret = 1'b1;
      else if (policy == rqps_pkg::POL_FCFS) begin
        if (r.fetch_outcome == rqps_pkg::OC_EXECUTED) begin
          running.pc++;
          if (running.pc >= running.len) ret = 1'b1;
        end
      end else if (policy == rqps_pkg::POL_AGING) begin
        if (r.fetch_outcome == rqps_pkg::OC_EXECUTED) running.pc++;
        foreach (ready_q[i]) if (ready_q[i].score != 0) ready_q[i].score--;
        if (running.pc >= running.len) ret = 1'b1;
        else if (ready_q.size() < DEPTH) begin
          ready_q.insert(score_slot(running), running);
          running_valid = 1'b0;
        end
      end else begin
        requeue = 1'b1;
        if (r.fetch_outcome == rqps_pkg::OC_EXECUTED) begin
          running.pc++;
          turns++;
          if (running.pc >= running.len) begin
            ret = 1'b1;
            requeue = 1'b0;
          end else if (turns < quantum) requeue = 1'b0;
        end
        if (requeue) begin
          if (ready_q.size() < DEPTH) begin
            ready_q.push_back(running);
            running_valid = 1'b0;
          end else turns = '0;
        end
      end
      if (ret) begin
        ret_id = running.id;
        running_valid = 1'b0;
        running = '0;
      end
    end
    if (!running_valid && ready_q.size() > 0) begin
      running = ready_q.pop_front();
      running_valid = 1'b1;
      turns = '0;
    end
    o.fetch_valid = running_valid;
    o.fetch_proc = running_valid ? running.id : '0;
    o.fetch_line = running_valid ? running.pc : '0;
    o.retired_valid = ret;
    o.retired_proc = ret_id;
    o.status = st;
    o.waiting_count = 5'(ready_q.size());
    return o;
  endfunction

  // predict at each accepted transaction
  always @(posedge clk) begin
    was_accepted <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      expected_outcomes.push_back(schedule(pending_requests.pop_front()));
    end
  end

  // driver: one transaction per accepted item, gaps between
  always @(negedge clk) begin
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !was_accepted) begin
      // hold payload until accepted
    end else if (gap > 0) begin
      gap <= gap - 1;
      in_valid <= 1'b0;
    end else if (pending_requests.size() > 0) begin
      r = pending_requests[0];
      in_valid <= 1'b1;
      cmd <= r.cmd;
      proc_id <= r.proc_id;
      line_count <= r.line_count;
      start_score <= r.start_score;
      fetch_outcome <= r.fetch_outcome;
      gap <= rand_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall, with optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (rand_gap() != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t got, exp_o;
    if (!rst && out_valid && !out_stall) begin
      got = '{fetch_valid, fetch_proc, fetch_line, retired_valid, retired_proc, status,
              waiting_count};
      if (expected_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp_o = expected_outcomes.pop_front();
        if (got !== exp_o) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h actual %h", exp_o, got);
        end
      end
    end
  end

  function automatic request_t random_request(int fill_bias);
    request_t r;
    r.cmd = ($urandom_range(0, 9) < fill_bias) ? 2'($urandom_range(0, 1)) :
            (($urandom_range(0, 19) == 0) ? 2'd3 : rqps_pkg::CMD_REPORT);
    r.proc_id = 8'($urandom);
    r.line_count = ($urandom_range(0, 9) == 0) ? 10'($urandom) :
                   (($urandom_range(0, 19) == 0) ? 10'd0 : 10'($urandom_range(1, 6)));
    r.start_score = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 8));
    r.fetch_outcome = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                  : 2'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic drain();
    while (pending_requests.size() > 0 || expected_outcomes.size() > 0 || in_valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [5:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == rqps_pkg::REG_POLICY) policy = val[1:0];
    else quantum = (val == 0) ? 6'd1 : val;
  endtask

  initial begin
    running = '0;
    running_valid = 1'b0;
    turns = '0;
    policy = rqps_pkg::POLICY_RESET;
    quantum = rqps_pkg::QUANTUM_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes and special cases in FCFS
    pending_requests.push_back('{rqps_pkg::CMD_REPORT, 8'h00, 10'd0, 10'd0,
                                 rqps_pkg::OC_EXECUTED});
    pending_requests.push_back('{rqps_pkg::CMD_ADMIT_TAIL, 8'hFF, 10'd0, 10'd5,
                                 rqps_pkg::OC_EXECUTED});
    pending_requests.push_back('{rqps_pkg::CMD_ADMIT_TAIL, 8'hFF, 10'h3FF, 10'h3FF, 2'd3});
    pending_requests.push_back('{rqps_pkg::CMD_ADMIT_FRONT, 8'h00, 10'd2, 10'd0,
                                 rqps_pkg::OC_EXECUTED});
    pending_requests.push_back('{2'd3, 8'hAA, 10'd1, 10'd1, rqps_pkg::OC_FAULT});
    pending_requests.push_back('{rqps_pkg::CMD_REPORT, 8'h00, 10'd0, 10'd0,
                                 rqps_pkg::OC_FAULT});
    pending_requests.push_back('{rqps_pkg::CMD_REPORT, 8'h00, 10'd0, 10'd0,
                                 rqps_pkg::OC_EXECUTED});
    pending_requests.push_back('{rqps_pkg::CMD_REPORT, 8'h00, 10'd0, 10'd0,
                                 rqps_pkg::OC_EXECUTED});
    pending_requests.push_back('{rqps_pkg::CMD_REPORT, 8'h00, 10'd0, 10'd0, 2'd2});
    for (int i = 0; i < 18; i++)
      pending_requests.push_back('{rqps_pkg::CMD_ADMIT_TAIL, 8'(i), 10'd3, 10'(i % 4),
                                   rqps_pkg::OC_EXECUTED});
    drain();

    // long hold-off while sender keeps going
    for (int i = 0; i < 30; i++) pending_requests.push_back(random_request(5));
    hold_off = 200;
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(rqps_pkg::REG_POLICY, 6'd1);
          write_reg(rqps_pkg::REG_QUANTUM, 6'd0);
        end
        1: write_reg(rqps_pkg::REG_QUANTUM, 6'd63);
        2: begin
          write_reg(rqps_pkg::REG_POLICY, 6'd2);
          write_reg(rqps_pkg::REG_QUANTUM, 6'd1);
        end
        3: write_reg(rqps_pkg::REG_POLICY, 6'd3);
        4: begin
          write_reg(rqps_pkg::REG_POLICY, 6'd0);
          write_reg(rqps_pkg::REG_QUANTUM, 6'd3);
        end
        5: write_reg(rqps_pkg::REG_POLICY, 6'd2);
        6: begin
          write_reg(rqps_pkg::REG_POLICY, 6'd1);
          write_reg(rqps_pkg::REG_QUANTUM, 6'd2);
        end
        default: write_reg(rqps_pkg::REG_POLICY, 6'd2);
      endcase
      for (int i = 0; i < 62; i++) pending_requests.push_back(random_request(phase[0] ? 4 : 6));
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
